FILE: sv/arxks_pkg.sv
// Shared types, constants and the microprogram of the add-xor-rotate keystream block.
package arxks_pkg;

    localparam int WORD_W       = 64;
    localparam int NUM_WORDS    = 8;
    localparam int NUM_BYTES    = 8;
    localparam int COUNT_W      = 4;
    localparam int ROT_AMOUNT   = 9;
    localparam int UPC_W        = 4;
    localparam int IDX_W        = 3;
    localparam int RND_W        = 6;
    localparam int CFG_IDX_W    = 3;

    localparam logic [RND_W-1:0] ROUNDS_EARLY = RND_W'(2);
    localparam logic [RND_W-1:0] ROUNDS_LATE  = RND_W'(62);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE1 = 3'd5;

    localparam logic [UPC_W-1:0] UPC_SETUP = 4'd0;
    localparam logic [UPC_W-1:0] UPC_DATA  = 4'd7;
    localparam logic [UPC_W-1:0] UPC_LAST  = 4'd10;

    typedef logic [WORD_W-1:0]                t_word;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_words;
    typedef logic [3:0][WORD_W-1:0]           t_key;
    typedef logic [1:0][WORD_W-1:0]           t_nonce;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SUMW,
        OP_MIX,
        OP_FF,
        OP_KS,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_IDX,
        JMP_RND
    } t_jmp;

    typedef enum logic [1:0] {
        RND_KEEP,
        RND_EARLY,
        RND_LATE
    } t_rnd;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef struct packed {
        t_op              op;
        t_jmp             jmp;
        logic [UPC_W-1:0] tgt;
        logic [IDX_W-1:0] idx_last;
        t_rnd             rnd;
        logic             fin;
    } t_uword;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_ctl;

    function automatic t_uword uw(input t_op op, input t_jmp jmp, input logic [UPC_W-1:0] tgt,
                                  input logic [IDX_W-1:0] idx_last, input t_rnd rnd,
                                  input logic fin);
        t_uword u;
        u.op       = op;
        u.jmp      = jmp;
        u.tgt      = tgt;
        u.idx_last = idx_last;
        u.rnd      = rnd;
        u.fin      = fin;
        return u;
    endfunction

    // Key setup occupies steps 0 to 6 and a data word steps 7 to 10.
    function automatic t_uword urom(input logic [UPC_W-1:0] a);
        t_uword u;
        case (a)
            4'd0:    u = uw(OP_LOAD, JMP_NEXT, 4'd0,  3'd0, RND_EARLY, 1'b0);
            4'd1:    u = uw(OP_SUMW, JMP_IDX,  4'd1,  3'd7, RND_KEEP,  1'b0);
            4'd2:    u = uw(OP_MIX,  JMP_IDX,  4'd2,  3'd7, RND_KEEP,  1'b0);
            4'd3:    u = uw(OP_FF,   JMP_RND,  4'd2,  3'd0, RND_KEEP,  1'b0);
            4'd4:    u = uw(OP_SUMW, JMP_IDX,  4'd4,  3'd7, RND_LATE,  1'b0);
            4'd5:    u = uw(OP_MIX,  JMP_IDX,  4'd5,  3'd7, RND_KEEP,  1'b0);
            4'd6:    u = uw(OP_FF,   JMP_RND,  4'd5,  3'd0, RND_KEEP,  1'b1);
            4'd7:    u = uw(OP_MIX,  JMP_IDX,  4'd7,  3'd7, RND_KEEP,  1'b0);
            4'd8:    u = uw(OP_FF,   JMP_NEXT, 4'd0,  3'd0, RND_KEEP,  1'b0);
            4'd9:    u = uw(OP_KS,   JMP_IDX,  4'd9,  3'd3, RND_KEEP,  1'b0);
            4'd10:   u = uw(OP_EMIT, JMP_NEXT, 4'd0,  3'd0, RND_KEEP,  1'b1);
            default: u = uw(OP_NOP,  JMP_NEXT, 4'd0,  3'd0, RND_KEEP,  1'b1);
        endcase
        return u;
    endfunction

    // Word added at each step of the keystream fold.
    function automatic logic [IDX_W-1:0] ks_add_sel(input logic [1:0] step);
        logic [IDX_W-1:0] sel;
        case (step)
            2'd0:    sel = 3'd6;
            2'd1:    sel = 3'd5;
            2'd2:    sel = 3'd4;
            default: sel = 3'd7;
        endcase
        return sel;
    endfunction

    function automatic t_word rotl9(input t_word v);
        return {v[WORD_W-ROT_AMOUNT-1:0], v[WORD_W-1:WORD_W-ROT_AMOUNT]};
    endfunction

endpackage

FILE: sv/arx_stream_cipher_keystream.sv
// Top level of the add-xor-rotate keystream cipher: ports, settings, input and result registers.
//
//  Channel  | Handshake                          | Carries
//  ---------+------------------------------------+------------------------------------------
//  input    | i_in_valid / o_in_stall            | i_mode, i_data_in, i_byte_count
//  result   | o_out_valid / i_out_stall          | o_data_out, o_valid_bytes
//  settings | i_cfg_wr_en, i_cfg_index           | i_cfg_data (key and nonce words)
//
// A data item runs a round of 8 mix steps and one feedforward step, 4 keystream fold steps
// and one step that loads the result register.
// Key setup is a load, two 8-step sums and 64 rounds of 9 steps.
// The sequencer handles one item at a time; a new item is taken the cycle after it finishes.
// Reset clears the settings, the mix words and the accumulator to zero.
// A pending result that is stalled holds the final step until it is taken.
module arx_stream_cipher_keystream import arxks_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [WORD_W-1:0]    i_data_in,
    input  logic [COUNT_W-1:0]   i_byte_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [WORD_W-1:0]    o_data_out,
    output logic [COUNT_W-1:0]   o_valid_bytes
);

    t_key               r_key;
    t_nonce             r_nonce;
    t_word              r_data;
    logic [COUNT_W-1:0] r_cnt;
    logic               r_ov;
    t_word              r_dout;
    logic [COUNT_W-1:0] r_vb;
    logic               busy;
    logic               in_acc;
    logic               start;
    logic               emit_block;
    logic               emit;
    t_ctl               ctl;
    t_word              ks;
    t_word              mask;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign start      = in_acc && (!i_mode || (i_byte_count != '0));
    assign emit_block = r_ov && i_out_stall;
    assign emit       = (ctl.op == OP_EMIT) && !emit_block;

    arxks_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_setup      (!i_mode),
        .i_emit_block (emit_block),
        .o_busy       (busy),
        .o_ctl        (ctl)
    );

    arxks_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_key   (r_key),
        .i_nonce (r_nonce),
        .o_ks    (ks)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_nonce <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KEY0:   r_key[0]   <= i_cfg_data;
                CFG_KEY1:   r_key[1]   <= i_cfg_data;
                CFG_KEY2:   r_key[2]   <= i_cfg_data;
                CFG_KEY3:   r_key[3]   <= i_cfg_data;
                CFG_NONCE0: r_nonce[0] <= i_cfg_data;
                CFG_NONCE1: r_nonce[1] <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_data <= i_data_in;
            r_cnt  <= (i_byte_count > COUNT_W'(NUM_BYTES)) ? COUNT_W'(NUM_BYTES) : i_byte_count;
        end
    end

    always_comb begin
        for (int b = 0; b < NUM_BYTES; b++) begin
            mask[8*b +: 8] = {8{COUNT_W'(b) < r_cnt}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_dout <= (r_data ^ ks) & mask;
            r_vb   <= r_cnt;
        end
    end

    assign o_in_stall    = busy;
    assign o_out_valid   = r_ov;
    assign o_data_out    = r_dout;
    assign o_valid_bytes = r_vb;

`ifndef SYNTHESIS
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(ctl.op == OP_EMIT))
        else $error("result appeared without a final step");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_vb != '0 && r_vb <= COUNT_W'(NUM_BYTES)))
        else $error("result byte count out of range");
    a_setup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_mode) |=> (o_in_stall && !emit))
        else $error("key setup did not hold off the input");
`endif

endmodule

FILE: sv/arxks_seq.sv
// Microcoded sequencer: step counter, word index, round counter and program table.
module arxks_seq import arxks_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_setup,
    input  logic i_emit_block,
    output logic o_busy,
    output t_ctl o_ctl
);

    t_seq_state       r_state, n_state;
    logic [UPC_W-1:0] r_upc, n_upc;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [RND_W-1:0] r_rnd, n_rnd;
    t_uword           cur;
    logic             hold;
    logic             go_next;

    assign cur  = urom(r_upc);
    assign hold = (cur.op == OP_EMIT) && i_emit_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_upc   <= UPC_SETUP;
            r_idx   <= '0;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
            r_idx   <= n_idx;
            r_rnd   <= n_rnd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_upc   = r_upc;
        n_idx   = r_idx;
        n_rnd   = r_rnd;
        go_next = 1'b0;
        case (r_state)
            SEQ_IDLE: begin
                if (i_start) begin
                    n_state = SEQ_RUN;
                    n_upc   = i_setup ? UPC_SETUP : UPC_DATA;
                    n_idx   = '0;
                end
            end
            SEQ_RUN: begin
                if (!hold) begin
                    case (cur.rnd)
                        RND_EARLY: n_rnd = ROUNDS_EARLY;
                        RND_LATE:  n_rnd = ROUNDS_LATE;
                        default:   ;
                    endcase
                    case (cur.jmp)
                        JMP_IDX: begin
                            if (r_idx != cur.idx_last) begin
                                n_idx = r_idx + IDX_W'(1);
                                n_upc = cur.tgt;
                            end else begin
                                n_idx   = '0;
                                go_next = 1'b1;
                            end
                        end
                        JMP_RND: begin
                            n_rnd = r_rnd - RND_W'(1);
                            if (r_rnd != RND_W'(1)) begin
                                n_upc = cur.tgt;
                            end else begin
                                go_next = 1'b1;
                            end
                        end
                        default: go_next = 1'b1;
                    endcase
                    if (go_next) begin
                        if (cur.fin) begin
                            n_state = SEQ_IDLE;
                        end else begin
                            n_upc = r_upc + UPC_W'(1);
                        end
                    end
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    assign o_busy    = (r_state != SEQ_IDLE);
    assign o_ctl.op  = (r_state == SEQ_RUN) ? cur.op : OP_NOP;
    assign o_ctl.idx = r_idx;

`ifndef SYNTHESIS
    a_upc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_RUN) |-> (r_upc <= UPC_LAST))
        else $error("step counter left the program");
    a_round_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_RUN && cur.jmp == JMP_RND) |-> (r_rnd != '0))
        else $error("round counter empty at a round jump");
    a_idx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_RUN && cur.jmp == JMP_IDX) |-> (r_idx <= cur.idx_last))
        else $error("word index beyond its loop limit");
`endif

endmodule

FILE: sv/arxks_dp.sv
// Datapath: mix words, snapshot for feedforward, accumulator and keystream fold.
module arxks_dp import arxks_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctl   i_ctl,
    input  t_key   i_key,
    input  t_nonce i_nonce,
    output t_word  o_ks
);

    t_words r_w, n_w;
    t_words r_before, n_before;
    t_word  r_acc, n_acc;
    t_word  r_pend, n_pend;
    t_word  r_ks, n_ks;
    t_word  w_cur;
    t_word  w_nb;
    t_word  mix_t;
    t_word  ks_base;
    logic [IDX_W-1:0] nb_idx;

    // The accumulator lags by one word: r_pend holds the last mixed word not yet added.
    assign nb_idx  = i_ctl.idx + IDX_W'(1);
    assign w_cur   = r_w[i_ctl.idx];
    assign w_nb    = r_w[nb_idx];
    assign mix_t   = rotl9((w_cur + w_nb + r_acc + r_pend) ^ w_cur);
    assign ks_base = (i_ctl.idx[1:0] == 2'd0) ? r_w[0]
                                              : (r_ks ^ r_w[{1'b0, i_ctl.idx[1:0]}]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= '0;
            r_acc  <= '0;
            r_pend <= '0;
        end else begin
            r_w    <= n_w;
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_before <= n_before;
        r_ks     <= n_ks;
    end

    always_comb begin
        n_w      = r_w;
        n_before = r_before;
        n_acc    = r_acc;
        n_pend   = r_pend;
        n_ks     = r_ks;
        case (i_ctl.op)
            OP_LOAD: begin
                n_w[0] = i_key[0] ^ i_nonce[0];
                n_w[1] = i_key[1] ^ i_nonce[1];
                n_w[2] = i_key[2];
                n_w[3] = i_key[3];
                n_w[4] = '0;
                n_w[5] = '0;
                n_w[6] = '0;
                n_w[7] = '0;
                n_acc  = '0;
                n_pend = '0;
            end
            OP_SUMW: begin
                n_acc = r_acc + w_cur;
            end
            OP_MIX: begin
                n_w[i_ctl.idx] = mix_t;
                n_pend         = mix_t;
                n_acc          = r_acc + r_pend;
                if (i_ctl.idx == '0) begin
                    n_before = r_w;
                end
            end
            OP_FF: begin
                for (int k = 0; k < NUM_WORDS; k++) begin
                    n_w[k] = r_w[k] + r_before[k];
                end
                n_acc  = r_acc + r_pend;
                n_pend = '0;
            end
            OP_KS: begin
                n_ks = ks_base + r_w[ks_add_sel(i_ctl.idx[1:0])];
            end
            default: ;
        endcase
    end

    assign o_ks = r_ks;

endmodule
